[design/ofp_pkg.sv]
`timescale 1ns / 1ps

package ofp_pkg;

  localparam int IDX_W = 32;
  localparam logic [IDX_W-1:0] IDX_CAP = IDX_W'(1) << (IDX_W - 1);
  localparam int ACC_EXT_W = IDX_W + 4;
  localparam int OUT_W = 32;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  typedef enum logic [2:0] {
    CLS_DIGIT,
    CLS_PLUS,
    CLS_MINUS,
    CLS_SLASH,
    CLS_SPACE,
    CLS_OTHER
  } ofp_cls_t;

  typedef struct packed {
    ofp_cls_t   cls;
    logic [3:0] digit;
  } ofp_tok_t;

  typedef enum logic [1:0] {
    KIND_V   = 2'd0,
    KIND_VT  = 2'd1,
    KIND_VN  = 2'd2,
    KIND_VTN = 2'd3
  } ofp_kind_t;

  typedef enum logic {
    ST_IDLE,
    ST_POINT
  } ofp_state_t;

  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_THIRD  = 2'd2;

  // sign-extend or truncate an index to the output width
  function automatic logic [OUT_W-1:0] to_out(logic [IDX_W-1:0] v);
    logic signed [IDX_W-1:0] s;
    s = signed'(v);
    return OUT_W'(64'(s));
  endfunction

endpackage

[design/ofp_front.sv]
`timescale 1ns / 1ps

module ofp_front (
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [7:0]      s_tdata,   // [7:0] ch
  input  logic            q_full,
  output logic            q_push,
  output ofp_pkg::ofp_tok_t q_tok
);

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  always_comb begin
    q_tok.digit = s_tdata[3:0];
    unique case (s_tdata) inside
      [8'h30:8'h39]:          q_tok.cls = ofp_pkg::CLS_DIGIT;
      8'h2B:                  q_tok.cls = ofp_pkg::CLS_PLUS;
      8'h2D:                  q_tok.cls = ofp_pkg::CLS_MINUS;
      8'h2F:                  q_tok.cls = ofp_pkg::CLS_SLASH;
      8'h00, 8'h20, [8'h09:8'h0D]: q_tok.cls = ofp_pkg::CLS_SPACE;
      default:                q_tok.cls = ofp_pkg::CLS_OTHER;
    endcase
  end

endmodule

[design/ofp_tok_fifo.sv]
`timescale 1ns / 1ps

module ofp_tok_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ofp_pkg::ofp_tok_t push_tok,
  output logic              full,
  input  logic              pop,
  output logic              pop_valid,
  output ofp_pkg::ofp_tok_t pop_tok
);

  ofp_pkg::ofp_tok_t                mem [ofp_pkg::FIFO_DEPTH];
  logic [ofp_pkg::FIFO_PTR_W-1:0]   wr_ptr;
  logic [ofp_pkg::FIFO_PTR_W-1:0]   rd_ptr;
  logic [ofp_pkg::FIFO_PTR_W:0]     count;
  logic                             do_pop;

  assign full      = (count == (ofp_pkg::FIFO_PTR_W + 1)'(ofp_pkg::FIFO_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_tok   = mem[rd_ptr];
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[design/ofp_back.sv]
`timescale 1ns / 1ps

module ofp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              tok_valid,
  input  ofp_pkg::ofp_tok_t tok,
  output logic              tok_ready,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [95:0]       m_tdata,  // [31:0] vertex_index, [63:32] texcoord_index,
                                      // [95:64] normal_index
  output logic [3:0]        m_tuser   // [1:0] point_kind, [2] range_error, [3] kind_mismatch
);

  ofp_pkg::ofp_state_t          state, state_next;
  logic [1:0]                   pos, pos_next;
  logic [ofp_pkg::IDX_W-1:0]    acc, acc_next;
  logic                         neg, neg_next;
  logic                         started, started_next;
  logic [ofp_pkg::IDX_W-1:0]    saved_first, saved_first_next;
  logic [ofp_pkg::IDX_W-1:0]    saved_second, saved_second_next;
  logic                         ovf, ovf_next;
  logic                         rk_valid;
  ofp_pkg::ofp_kind_t           rk;

  logic                         pop, act, is_sign, is_bad, emit;
  logic [ofp_pkg::ACC_EXT_W-1:0] acc_ext, prod;
  logic [ofp_pkg::IDX_W-1:0]    fin_val;
  logic                         fin_ovf;
  logic [ofp_pkg::IDX_W-1:0]    v_val, t_val, n_val;
  ofp_pkg::ofp_kind_t           kind;

  logic                         out_valid;
  logic [ofp_pkg::OUT_W-1:0]    out_v, out_t, out_n;
  ofp_pkg::ofp_kind_t           out_kind;
  logic                         out_range, out_mis;

  assign tok_ready = !out_valid || m_tready;
  assign pop       = tok_valid && tok_ready;
  assign act       = pop && (state == ofp_pkg::ST_POINT || tok.cls != ofp_pkg::CLS_SPACE);
  assign is_sign   = (tok.cls == ofp_pkg::CLS_PLUS) || (tok.cls == ofp_pkg::CLS_MINUS);
  assign is_bad    = (tok.cls == ofp_pkg::CLS_OTHER) || (is_sign && started);
  assign emit      = act && (is_bad || tok.cls == ofp_pkg::CLS_SPACE ||
                             (tok.cls == ofp_pkg::CLS_SLASH && pos == ofp_pkg::POS_THIRD));

  // times ten plus digit, saturating at the cap
  assign acc_ext = ofp_pkg::ACC_EXT_W'(acc);
  assign prod    = (acc_ext << 3) + (acc_ext << 1) + ofp_pkg::ACC_EXT_W'(tok.digit);

  // close the current field, clamped to the signed limits
  always_comb begin
    fin_ovf = 1'b0;
    if (neg) begin
      if (acc >= ofp_pkg::IDX_CAP) begin
        fin_ovf = 1'b1;
        fin_val = '0 - ofp_pkg::IDX_CAP;
      end else begin
        fin_val = '0 - acc;
      end
    end else begin
      if (acc >= ofp_pkg::IDX_CAP - 1'b1) begin
        fin_ovf = 1'b1;
        fin_val = ofp_pkg::IDX_CAP - 1'b1;
      end else begin
        fin_val = acc;
      end
    end
  end

  always_comb begin
    unique case (pos)
      ofp_pkg::POS_FIRST: begin
        v_val = fin_val;
        t_val = '0;
        n_val = '0;
        kind  = ofp_pkg::KIND_V;
      end
      ofp_pkg::POS_SECOND: begin
        v_val = saved_first;
        t_val = fin_val;
        n_val = '0;
        kind  = ofp_pkg::KIND_VT;
      end
      default: begin
        v_val = saved_first;
        t_val = saved_second;
        n_val = fin_val;
        kind  = (saved_second == '0) ? ofp_pkg::KIND_VN : ofp_pkg::KIND_VTN;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ofp_pkg::ST_IDLE: begin
        if (act && !emit) state_next = ofp_pkg::ST_POINT;
      end
      ofp_pkg::ST_POINT: begin
        if (emit) state_next = ofp_pkg::ST_IDLE;
      end
      default: state_next = ofp_pkg::ST_IDLE;
    endcase
  end

  // field registers
  always_comb begin
    pos_next          = pos;
    acc_next          = acc;
    neg_next          = neg;
    started_next      = started;
    saved_first_next  = saved_first;
    saved_second_next = saved_second;
    ovf_next          = ovf;
    if (emit) begin
      pos_next          = ofp_pkg::POS_FIRST;
      acc_next          = '0;
      neg_next          = 1'b0;
      started_next      = 1'b0;
      saved_first_next  = '0;
      saved_second_next = '0;
      ovf_next          = 1'b0;
    end else if (act) begin
      case (tok.cls)
        ofp_pkg::CLS_DIGIT: begin
          started_next = 1'b1;
          if (prod > ofp_pkg::ACC_EXT_W'(ofp_pkg::IDX_CAP)) begin
            acc_next = ofp_pkg::IDX_CAP;
          end else begin
            acc_next = prod[ofp_pkg::IDX_W-1:0];
          end
        end
        ofp_pkg::CLS_PLUS, ofp_pkg::CLS_MINUS: begin
          started_next = 1'b1;
          neg_next     = (tok.cls == ofp_pkg::CLS_MINUS);
        end
        ofp_pkg::CLS_SLASH: begin
          ovf_next     = ovf || fin_ovf;
          acc_next     = '0;
          neg_next     = 1'b0;
          started_next = 1'b0;
          if (pos == ofp_pkg::POS_FIRST) begin
            saved_first_next = fin_val;
            pos_next         = ofp_pkg::POS_SECOND;
          end else begin
            saved_second_next = fin_val;
            pos_next          = ofp_pkg::POS_THIRD;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ofp_pkg::ST_IDLE;
      pos          <= ofp_pkg::POS_FIRST;
      acc          <= '0;
      neg          <= 1'b0;
      started      <= 1'b0;
      saved_first  <= '0;
      saved_second <= '0;
      ovf          <= 1'b0;
      rk_valid     <= 1'b0;
      rk           <= ofp_pkg::KIND_V;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      pos          <= pos_next;
      acc          <= acc_next;
      neg          <= neg_next;
      started      <= started_next;
      saved_first  <= saved_first_next;
      saved_second <= saved_second_next;
      ovf          <= ovf_next;
      if (emit) begin
        rk_valid  <= 1'b1;
        rk        <= kind;
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_v     <= ofp_pkg::to_out(v_val);
      out_t     <= ofp_pkg::to_out(t_val);
      out_n     <= ofp_pkg::to_out(n_val);
      out_kind  <= kind;
      out_range <= ovf || fin_ovf || is_bad;
      out_mis   <= rk_valid && (rk != kind);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_n, out_t, out_v};
  assign m_tuser  = {out_mis, out_range, out_kind};

endmodule

[design/obj_face_point_parser.sv]
// OBJ face point parser. Takes one character of a face line per transfer and
// emits one result per point (three indices, kind, range and kind-mismatch
// flags) when whitespace, NUL, a bad character or a third '/' ends the point.
// It sustains one character per clock while the token queue is not full; the limit
// is the back end's times-ten-plus-digit accumulator update. A result is
// registered in the back end's output register after the character that ends
// the point has passed through the token queue. A four-entry token queue
// separates the character classifier from the parser, so while a result waits
// to be taken the input side keeps accepting characters until the queue holds four.
`timescale 1ns / 1ps

module obj_face_point_parser (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] ch
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [95:0]  m_tdata,   // [31:0] vertex_index, [63:32] texcoord_index,
                                  // [95:64] normal_index
  output logic [3:0]   m_tuser    // [1:0] point_kind, [2] range_error, [3] kind_mismatch
);

  logic              q_full, q_push, q_pop, q_valid;
  ofp_pkg::ofp_tok_t q_in_tok, q_out_tok;

  ofp_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_tok    (q_in_tok)
  );

  ofp_tok_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_tok  (q_in_tok),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_tok   (q_out_tok)
  );

  ofp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (q_valid),
    .tok       (q_out_tok),
    .tok_ready (q_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

[design/ofp_checker.sv]
`timescale 1ns / 1ps

module ofp_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [95:0]  m_tdata,
  input logic [3:0]   m_tuser
);

  // a held result does not change
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_kind_v: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1:0] == ofp_pkg::KIND_V |-> m_tdata[95:32] == '0)
    else $error("plain vertex point carries extra indices");

  a_kind_vt: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1:0] == ofp_pkg::KIND_VT |-> m_tdata[95:64] == '0)
    else $error("v/vt point carries a normal index");

  a_kind_vn: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[1:0] == ofp_pkg::KIND_VN) != (m_tuser[1:0] == ofp_pkg::KIND_VN &&
    m_tdata[63:32] == '0) |-> 1'b0)
    else $error("v//vn kind disagrees with texcoord index");

endmodule

bind obj_face_point_parser ofp_checker u_chk (.*);

[dv/ofp_point_checker.sv]
`timescale 1ns / 1ps

module ofp_point_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] ch
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [95:0]  m_tdata,   // [31:0] vertex_index, [63:32] texcoord_index,
                                  // [95:64] normal_index
  input  logic [3:0]   m_tuser,   // [1:0] point_kind, [2] range_error, [3] kind_mismatch
  output int           errors,
  output int           pending
);

  typedef struct packed {
    logic [31:0]        vtx;
    logic [31:0]        tex;
    logic [31:0]        nrm;
    ofp_pkg::ofp_kind_t kind;
    logic               range_err;
    logic               kind_mis;
  } point_t;

  localparam logic [63:0] CAP     = 64'(1) << (ofp_pkg::IDX_W - 1);
  localparam logic [2:0]  NO_KIND = 3'd4;

  point_t      points_due[$];
  int          err_cnt = 0;

  logic        in_pt;
  logic [1:0]  fpos;
  logic [63:0] acc;
  logic        neg;
  logic        started;
  logic [63:0] sv1;
  logic [63:0] sv2;
  logic        ovf;
  logic [2:0]  last_kind;

  function automatic void clear_field();
    acc     = '0;
    neg     = 1'b0;
    started = 1'b0;
  endfunction

  function automatic void clear_point();
    in_pt = 1'b0;
    fpos  = ofp_pkg::POS_FIRST;
    ovf   = 1'b0;
    sv1   = '0;
    sv2   = '0;
    clear_field();
  endfunction

  // signed value of the field just ended, clamped to the index limits
  function automatic logic [63:0] close_field();
    logic [63:0] v;
    v = acc;
    if (neg) begin
      if (v >= CAP) begin
        ovf = 1'b1;
        v = CAP;
      end
      v = -v;
    end else if (v >= CAP - 64'd1) begin
      ovf = 1'b1;
      v = CAP - 64'd1;
    end
    clear_field();
    return v;
  endfunction

  function automatic point_t close_point(logic [63:0] last, logic bad);
    point_t p;
    ofp_pkg::ofp_kind_t k;
    case (fpos)
      ofp_pkg::POS_FIRST: begin
        p.vtx = last[31:0];
        p.tex = '0;
        p.nrm = '0;
        k = ofp_pkg::KIND_V;
      end
      ofp_pkg::POS_SECOND: begin
        p.vtx = sv1[31:0];
        p.tex = last[31:0];
        p.nrm = '0;
        k = ofp_pkg::KIND_VT;
      end
      default: begin
        p.vtx = sv1[31:0];
        p.tex = sv2[31:0];
        p.nrm = last[31:0];
        if (sv2 == 64'd0) k = ofp_pkg::KIND_VN;
        else k = ofp_pkg::KIND_VTN;
      end
    endcase
    p.kind      = k;
    p.range_err = ovf | bad;
    p.kind_mis  = (last_kind != NO_KIND) && (last_kind != {1'b0, k});
    last_kind   = {1'b0, k};
    clear_point();
    return p;
  endfunction

  function automatic bit parse_char(logic [7:0] c, output point_t p);
    logic [63:0] d;
    logic [63:0] v;
    logic        blank;
    blank = (c == " ") || (c >= 8'd9 && c <= 8'd13);
    p = '0;
    if (!in_pt) begin
      if (c == 8'd0 || blank) return 1'b0;
      clear_point();
      in_pt = 1'b1;
    end
    if (c >= "0" && c <= "9") begin
      d = 64'(c - "0");
      if (acc > (CAP - d) / 64'd10) acc = CAP;
      else acc = acc * 64'd10 + d;
      started = 1'b1;
      return 1'b0;
    end
    if ((c == "+" || c == "-") && !started) begin
      started = 1'b1;
      neg = (c == "-");
      return 1'b0;
    end
    if (c == "/") begin
      v = close_field();
      if (fpos == ofp_pkg::POS_FIRST) begin
        sv1 = v;
        fpos = ofp_pkg::POS_SECOND;
        return 1'b0;
      end
      if (fpos == ofp_pkg::POS_SECOND) begin
        sv2 = v;
        fpos = ofp_pkg::POS_THIRD;
        return 1'b0;
      end
      p = close_point(v, 1'b0);
      return 1'b1;
    end
    v = close_field();
    p = close_point(v, !(c == 8'd0 || blank));
    return 1'b1;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%08h, actual 0x%08h", $time, name, want, got);
      err_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    point_t got;
    point_t want;
    point_t p;
    if (rst) begin
      clear_point();
      last_kind = NO_KIND;
      points_due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.vtx       = m_tdata[31:0];
        got.tex       = m_tdata[63:32];
        got.nrm       = m_tdata[95:64];
        got.kind      = ofp_pkg::ofp_kind_t'(m_tuser[1:0]);
        got.range_err = m_tuser[2];
        got.kind_mis  = m_tuser[3];
        if (points_due.size() == 0) begin
          $display("%0t ns: unexpected transfer, expected none, actual 0x%h / 0x%h",
                   $time, m_tdata, m_tuser);
          err_cnt++;
        end else begin
          want = points_due.pop_front();
          check_field("vertex_index", want.vtx, got.vtx);
          check_field("texcoord_index", want.tex, got.tex);
          check_field("normal_index", want.nrm, got.nrm);
          check_field("point_kind", 32'(want.kind), 32'(got.kind));
          check_field("range_error", 32'(want.range_err), 32'(got.range_err));
          check_field("kind_mismatch", 32'(want.kind_mis), 32'(got.kind_mis));
        end
      end
      if (s_tvalid && s_tready) begin
        if (parse_char(s_tdata, p)) points_due = {points_due, p};
      end
    end
    errors  <= err_cnt;
    pending <= points_due.size();
  end

endmodule

[dv/tb_obj_face_point_parser.sv]
`timescale 1ns / 1ps

module tb_obj_face_point_parser;

  localparam int CYCLE_LIMIT = 200000;
  localparam int CHAR_TOTAL  = 1550;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = 8'd0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [95:0]  m_tdata;
  logic [3:0]   m_tuser;

  int errors;
  int pending;
  int cycles = 0;
  int sent = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  obj_face_point_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  ofp_point_checker chk (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .errors   (errors),
    .pending  (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic put_char(input logic [7:0] c);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
  endtask

  task automatic put_number(input longint unsigned v);
    logic [7:0] digs [0:19];
    int n;
    n = 0;
    do begin
      digs[n] = 8'("0" + v % 10);
      v = v / 10;
      n++;
    end while (v != 0);
    for (int i = n - 1; i >= 0; i--) put_char(digs[i]);
  endtask

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 6))
      0: return 8'd0;
      1: return 8'd9;
      2: return 8'd10;
      3: return 8'd11;
      4: return 8'd12;
      5: return 8'd13;
      default: return " ";
    endcase
  endfunction

  task automatic put_field(input bit empty_bias);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) put_char("+");
    else if (sel == 1) put_char("-");
    sel = $urandom_range(0, 19);
    if (empty_bias && $urandom_range(0, 2) == 0) sel = 11;
    if (sel <= 10) put_number($urandom_range(0, 9999));
    else if (sel <= 12) begin
      // empty field
    end else if (sel <= 15) put_number(64'd2147483640 + $urandom_range(0, 16));
    else if (sel <= 17) repeat ($urandom_range(10, 20)) put_char(8'("0" + $urandom_range(0, 9)));
    else put_number(64'($urandom()));
  endtask

  task automatic put_point();
    int nf;
    int sel;
    logic [7:0] c;
    if ($urandom_range(0, 99) < 15) begin
      // noise and broken sequences
      if ($urandom_range(0, 3) == 0) put_text("+-");
      repeat ($urandom_range(1, 6)) put_char(8'($urandom_range(0, 255)));
      return;
    end
    repeat ($urandom_range(0, 2)) put_char(blank_char());
    nf = $urandom_range(1, 3);
    for (int i = 0; i < nf; i++) begin
      if (i > 0) put_char("/");
      put_field(i == 1 && nf == 3);
    end
    sel = $urandom_range(0, 9);
    if (sel <= 5) put_char(blank_char());
    else if (sel == 6) begin
      if (nf == 3) put_char("/");
      else put_char(blank_char());
    end else if (sel == 7) put_char(8'd0);
    else if (sel == 8) begin
      c = 8'($urandom_range(0, 255));
      if ((c >= "0" && c <= "9") || c == "/" || c == "+" || c == "-") c = "#";
      put_char(c);
    end else begin
      put_char("/");
      put_char(blank_char());
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    put_text("7 1/-2\t3//4\n+5/6/7/- +-9z1");
    put_char(8'd0);
    put_char(8'd0);
    put_char(8'hFF);

    idle_pct = 0;
    stall_pct <= 0;
    while (sent < CHAR_TOTAL / 4) put_point();

    idle_pct = 78;
    while (sent < CHAR_TOTAL / 2) put_point();
    drain();

    idle_pct = 0;
    stall_pct <= 78;
    while (sent < 3 * CHAR_TOTAL / 4) put_point();

    idle_pct = 38;
    stall_pct <= 38;
    while (sent < CHAR_TOTAL) put_point();
    put_char(" ");

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
